### design/mcadp_pkg.sv
package mcadp_pkg;

    localparam int DEF_MAX_N     = 8;
    localparam int DEF_COST_BITS = 16;

    localparam int CFG_W      = 4;
    localparam int IDX_W      = 3;
    localparam int COST_IN_W  = 16;
    localparam int OUT_W      = 19;

    localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(8);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT_RD,
        ST_INIT_WR,
        ST_MASK_CHK,
        ST_CAND_RD,
        ST_CAND_ADD,
        ST_CAND_CMP,
        ST_MASK_WR,
        ST_FIN_RD,
        ST_FIN_OUT
    } state_t;

endpackage

### design/mcadp_ram.sv
module mcadp_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16,
    parameter int AW    = 6
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### design/min_cost_assignment_bitmask_dp_unit.sv
// Minimum-cost assignment engine. Load the n-by-n cost matrix one word per entry on the s_
// channel (row, column, cost); loading words are taken one per cycle while idle. The word
// marked last_entry is stored and then starts the solve, during which s_ready is low. The
// solve walks a subset-mask dynamic program with two layers in one memory, using a single
// adder and comparator: it seeds the first layer with one read and one write per task, then
// for every later person row it checks each mask and, for each mask of matching popcount,
// steps through the task bits, reading, adding and comparing for each set bit before one
// write; it then fetches the answer for the full mask. The layer memory has one read port.
// One result word carries the minimum sum; later loading words are taken while it waits.
module min_cost_assignment_bitmask_dp_unit
    import mcadp_pkg::*;
#(
    parameter int MAX_N     = DEF_MAX_N,
    parameter int COST_BITS = DEF_COST_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [IDX_W-1:0]     s_row_index,
    input  logic [IDX_W-1:0]     s_col_index,
    input  logic [COST_IN_W-1:0] s_cost_value,
    input  logic                 s_last_entry,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [OUT_W-1:0]     m_min_total_cost
);

    localparam int NW  = $clog2(MAX_N + 1);
    localparam int TW  = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int CAW = (MAX_N > 1) ? $clog2(MAX_N * MAX_N) : 1;
    localparam int DW  = COST_BITS + ((MAX_N > 1) ? $clog2(MAX_N) : 0);
    localparam int LAW = MAX_N + 1;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]     size_reg;
    logic [NW-1:0]        n_reg, n_next;
    logic [NW-1:0]        p_reg, p_next;
    logic [TW-1:0]        t_reg, t_next;
    logic [MAX_N-1:0]     m_reg, m_next;
    logic                 cur_reg, cur_next;
    logic [DW-1:0]        best_reg, best_next;
    logic                 have_reg, have_next;
    logic [DW-1:0]        sum_reg, sum_next;
    logic                 m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]     result_reg, result_next;

    logic                 in_fire;
    logic                 cost_we;
    logic [CAW-1:0]       cost_wr_addr;
    logic [COST_BITS-1:0] cost_wr_data;
    logic [CAW-1:0]       cost_rd_addr;
    logic [COST_BITS-1:0] cost_rd;

    logic                 dp_we;
    logic [LAW-1:0]       dp_wr_addr;
    logic [DW-1:0]        dp_wr_data;
    logic [LAW-1:0]       dp_rd_addr;
    logic [DW-1:0]        dp_rd;

    logic [NW-1:0]        n_eff;
    logic [MAX_N-1:0]     full_mask;
    logic [MAX_N-1:0]     t_bit;
    logic                 t_last;
    logic                 p_last;
    logic                 m_last;
    logic                 pc_match;
    logic                 out_free;

    assign in_fire      = s_valid && s_ready;
    assign cost_we      = in_fire && (int'(s_row_index) < MAX_N) && (int'(s_col_index) < MAX_N);
    assign cost_wr_addr = CAW'(int'(s_row_index) * MAX_N + int'(s_col_index));
    assign cost_wr_data = COST_BITS'(s_cost_value);
    assign cost_rd_addr = CAW'(int'(p_reg) * MAX_N + int'(t_reg));

    mcadp_ram #(
        .DEPTH (MAX_N * MAX_N),
        .WIDTH (COST_BITS),
        .AW    (CAW)
    ) u_cost_ram (
        .aclk    (aclk),
        .wr_en   (cost_we),
        .wr_addr (cost_wr_addr),
        .wr_data (cost_wr_data),
        .rd_addr (cost_rd_addr),
        .rd_data (cost_rd)
    );

    mcadp_ram #(
        .DEPTH (2 ** LAW),
        .WIDTH (DW),
        .AW    (LAW)
    ) u_layer_ram (
        .aclk    (aclk),
        .wr_en   (dp_we),
        .wr_addr (dp_wr_addr),
        .wr_data (dp_wr_data),
        .rd_addr (dp_rd_addr),
        .rd_data (dp_rd)
    );

    always_comb begin
        if (size_reg == '0) begin
            n_eff = NW'(1);
        end else if (int'(size_reg) > MAX_N) begin
            n_eff = NW'(MAX_N);
        end else begin
            n_eff = NW'(size_reg);
        end
        for (int i = 0; i < MAX_N; i++) begin
            full_mask[i] = (i < int'(n_reg));
        end
    end

    assign t_bit    = MAX_N'(1) << t_reg;
    assign t_last   = (NW'(t_reg) == n_reg - NW'(1));
    assign p_last   = (p_reg == n_reg - NW'(1));
    assign m_last   = (m_reg == full_mask);
    assign pc_match = ($countones(m_reg) == int'(p_reg) + 1);
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            size_reg    <= SIZE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                size_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg      <= n_next;
        p_reg      <= p_next;
        t_reg      <= t_next;
        m_reg      <= m_next;
        cur_reg    <= cur_next;
        best_reg   <= best_next;
        have_reg   <= have_next;
        sum_reg    <= sum_next;
        result_reg <= result_next;
    end

    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        p_next       = p_reg;
        t_next       = t_reg;
        m_next       = m_reg;
        cur_next     = cur_reg;
        best_next    = best_reg;
        have_next    = have_reg;
        sum_next     = sum_reg;
        result_next  = result_reg;
        m_valid_next = m_valid_reg && !m_ready;
        dp_we        = 1'b0;
        dp_wr_addr   = {cur_reg, m_reg};
        dp_wr_data   = best_reg;
        dp_rd_addr   = {~cur_reg, m_reg & ~t_bit};

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire && s_last_entry) begin
                    n_next     = n_eff;
                    p_next     = '0;
                    t_next     = '0;
                    cur_next   = 1'b0;
                    state_next = ST_INIT_RD;
                end
            end
            ST_INIT_RD: begin
                state_next = ST_INIT_WR;
            end
            ST_INIT_WR: begin
                dp_we      = 1'b1;
                dp_wr_addr = {1'b0, t_bit};
                dp_wr_data = DW'(cost_rd);
                t_next     = t_reg + TW'(1);
                state_next = ST_INIT_RD;
                if (t_last) begin
                    if (n_reg == NW'(1)) begin
                        state_next = ST_FIN_RD;
                    end else begin
                        p_next     = NW'(1);
                        m_next     = '0;
                        cur_next   = 1'b1;
                        state_next = ST_MASK_CHK;
                    end
                end
            end
            ST_MASK_CHK: begin
                if (pc_match) begin
                    t_next     = '0;
                    have_next  = 1'b0;
                    state_next = ST_CAND_RD;
                end else if (m_last) begin
                    m_next     = '0;
                    p_next     = p_reg + NW'(1);
                    cur_next   = ~cur_reg;
                    state_next = p_last ? ST_FIN_RD : ST_MASK_CHK;
                end else begin
                    m_next = m_reg + MAX_N'(1);
                end
            end
            ST_CAND_RD: begin
                if (m_reg[t_reg]) begin
                    state_next = ST_CAND_ADD;
                end else if (t_last) begin
                    state_next = ST_MASK_WR;
                end else begin
                    t_next = t_reg + TW'(1);
                end
            end
            ST_CAND_ADD: begin
                sum_next   = dp_rd + DW'(cost_rd);
                state_next = ST_CAND_CMP;
            end
            ST_CAND_CMP: begin
                if (!have_reg || (sum_reg < best_reg)) begin
                    best_next = sum_reg;
                    have_next = 1'b1;
                end
                if (t_last) begin
                    state_next = ST_MASK_WR;
                end else begin
                    t_next     = t_reg + TW'(1);
                    state_next = ST_CAND_RD;
                end
            end
            ST_MASK_WR: begin
                dp_we = 1'b1;
                if (m_last) begin
                    if (p_last) begin
                        state_next = ST_FIN_RD;
                    end else begin
                        m_next     = '0;
                        p_next     = p_reg + NW'(1);
                        cur_next   = ~cur_reg;
                        state_next = ST_MASK_CHK;
                    end
                end else begin
                    m_next     = m_reg + MAX_N'(1);
                    state_next = ST_MASK_CHK;
                end
            end
            ST_FIN_RD: begin
                dp_rd_addr = {cur_reg, full_mask};
                state_next = ST_FIN_OUT;
            end
            ST_FIN_OUT: begin
                dp_rd_addr = {cur_reg, full_mask};
                if (out_free) begin
                    m_valid_next = 1'b1;
                    result_next  = OUT_W'(dp_rd);
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_min_total_cost = result_reg;

endmodule

### design/mcadp_checker.sv
module mcadp_checker
    import mcadp_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             s_last_entry,
    input logic             m_valid,
    input logic             m_ready,
    input logic [OUT_W-1:0] m_min_total_cost
);

    // A stalled result word keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_min_total_cost))
        else $error("result word changed while stalled");

    // A final entry starts the solve, so the input side closes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_entry |=> !s_ready)
        else $error("input still open after the final entry");

    // A loading word never closes the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_last_entry |=> s_ready)
        else $error("input closed after a loading word");

    // A result word appears only at the end of a solve.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result word without a solve");

endmodule

bind min_cost_assignment_bitmask_dp_unit mcadp_checker u_mcadp_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_last_entry     (s_last_entry),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_min_total_cost (m_min_total_cost)
);
